### rtl/dqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_pkg
// Shared codes, field widths and control structs of the descriptor queue
// manager.
// ----------------------------------------------------------------------------
package dqm_pkg;

  // field widths
  localparam int ADDR_W = 32;
  localparam int HINT_W = 5;
  localparam int CNT_W  = 13;
  localparam int QNUM_W = 6;
  localparam int WORD_W = 32;

  // fixed constants
  localparam logic [ADDR_W-1:0] LOW_MASK  = 32'h0000_001F;
  localparam int                MIN_LOG   = 5;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 13'h1FFF;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEND = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [1:0] CFG_SIZE_CODE   = 2'd1;
  localparam logic [1:0] CFG_COUNT_CODE  = 2'd2;

  // shared adder request
  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              sub;
  } alu_req_t;

  // queue table write strobes
  typedef struct packed {
    logic head;
    logic tail;
    logic cnt;
    logic ne_set;
    logic ne_clr;
  } qt_we_t;

endpackage

### rtl/dqm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// command channel
interface dqm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  queue_number;
  logic [31:0] desc_address;
  logic [4:0]  size_hint;

  modport source (output valid, opcode, queue_number, desc_address, size_hint,
                  input ready);
  modport sink (input valid, opcode, queue_number, desc_address, size_hint,
                output ready);
endinterface

// result channel
interface dqm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] popped_address;
  logic [4:0]  popped_size_hint;
  logic        queue_was_empty;
  logic [31:0] pending_word;
  logic        push_rejected;

  modport source (output valid, popped_address, popped_size_hint,
                  queue_was_empty, pending_word, push_rejected, input ready);
  modport sink (input valid, popped_address, popped_size_hint,
                queue_was_empty, pending_word, push_rejected, output ready);
endinterface

// configuration write channel
interface dqm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/dqm_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_alu
// Shared 32-bit add/subtract unit used for address offset, address rebuild
// and entry count updates.
// ----------------------------------------------------------------------------
module dqm_alu import dqm_pkg::*; (
  input  alu_req_t          req,
  output logic [ADDR_W-1:0] sum,
  output logic              borrow
);

  logic [ADDR_W:0]   full_sum;
  logic [ADDR_W-1:0] b_op;

  // subtract as a + ~b + 1
  always_comb begin
    b_op     = req.sub ? ~req.b : req.b;
    full_sum = {1'b0, req.a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, req.sub};
    sum      = full_sum[ADDR_W-1:0];
    borrow   = req.sub & ~full_sum[ADDR_W];
  end

endmodule

### rtl/dqm_qtable.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_qtable
// Per-queue head, tail and entry count memories plus the non-empty flags.
// A queue whose flag is clear reads as empty whatever the memories hold.
// ----------------------------------------------------------------------------
module dqm_qtable import dqm_pkg::*; #(
  parameter int NUM_QUEUES = 64,
  parameter int IDX_W      = 12,
  parameter int QW         = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [QW-1:0]         rd_addr,
  output logic [IDX_W-1:0]      rd_head,
  output logic [IDX_W-1:0]      rd_tail,
  output logic [CNT_W-1:0]      rd_cnt,
  input  qt_we_t                we,
  input  logic [QW-1:0]         wr_addr,
  input  logic [IDX_W-1:0]      wr_head,
  input  logic [IDX_W-1:0]      wr_tail,
  input  logic [CNT_W-1:0]      wr_cnt,
  output logic [NUM_QUEUES-1:0] ne
);

  logic [IDX_W-1:0] head_mem [NUM_QUEUES];
  logic [IDX_W-1:0] tail_mem [NUM_QUEUES];
  logic [CNT_W-1:0] cnt_mem  [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] ne_r;
  logic [NUM_QUEUES-1:0] ne_nxt;

  // memory writes
  always_ff @(posedge clk) begin
    if (we.head) begin
      head_mem[wr_addr] <= wr_head;
    end
    if (we.tail) begin
      tail_mem[wr_addr] <= wr_tail;
    end
    if (we.cnt) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_head <= head_mem[rd_addr];
      rd_tail <= tail_mem[rd_addr];
      rd_cnt  <= cnt_mem[rd_addr];
    end
  end

  // non-empty flags
  always_comb begin
    ne_nxt = ne_r;
    if (we.ne_set) begin
      ne_nxt[wr_addr] = 1'b1;
    end
    if (we.ne_clr) begin
      ne_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= '0;
    end else begin
      ne_r <= ne_nxt;
    end
  end

  assign ne = ne_r;

endmodule

### rtl/dqm_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqm_link_mem
// Link store: next descriptor index and size hint, one entry per descriptor.
// ----------------------------------------------------------------------------
module dqm_link_mem import dqm_pkg::*; #(
  parameter int MAX_DESC = 4096,
  parameter int IDX_W    = 12
) (
  input  logic              clk,
  input  logic              link_we,
  input  logic [IDX_W-1:0]  link_waddr,
  input  logic [IDX_W-1:0]  link_wdata,
  input  logic              hint_we,
  input  logic [IDX_W-1:0]  hint_waddr,
  input  logic [HINT_W-1:0] hint_wdata,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [IDX_W-1:0]  rd_link,
  output logic [HINT_W-1:0] rd_hint
);

  logic [IDX_W-1:0]  link_mem [MAX_DESC];
  logic [HINT_W-1:0] hint_mem [MAX_DESC];

  // link array
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
    end
  end

  // hint array
  always_ff @(posedge clk) begin
    if (hint_we) begin
      hint_mem[hint_waddr] <= hint_wdata;
    end
    if (rd_en) begin
      rd_hint <= hint_mem[rd_addr];
    end
  end

endmodule

### rtl/descriptor_queue_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_queue_manager
// Keeps NUM_QUEUES FIFO queues of DMA descriptors threaded through a link
// store; push, pop and pending-word read under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_bus   in   opcode, queue_number, desc_address, size_hint
//  out_bus  out  popped_address, popped_size_hint, queue_was_empty,
//                pending_word, push_rejected
//  cfg_bus  in   index, data (register write, always ready)
//
//  push runs the offset check, then the tail append; pop the head rebuild,
//  then the link fetch. A rejected push or an empty pop skips the second
//  step; pending read and no-op go straight to the final step, which loads
//  the result register. Queue table and link store reads are registered.
//  in_bus is ready only while the sequencer is idle; a result waiting on
//  out_bus stalls only the final step; reset is synchronous, queues read empty.
// ----------------------------------------------------------------------------
module descriptor_queue_manager import dqm_pkg::*; #(
  parameter int NUM_QUEUES = 64,
  parameter int MAX_DESC   = 4096
) (
  input  logic   clk,
  input  logic   rst_n,
  dqm_in_if.sink    in_bus,
  dqm_out_if.source out_bus,
  dqm_cfg_if.sink   cfg_bus
);

  localparam int IDX_W = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int NW    = (NUM_QUEUES + WORD_W - 1) / WORD_W;
  localparam int WW    = (NW > 1) ? $clog2(NW) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PCHK = 3'd1;
  localparam logic [2:0] S_PWR  = 3'd2;
  localparam logic [2:0] S_POP1 = 3'd3;
  localparam logic [2:0] S_POP2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [ADDR_W-1:0] region_base_r;
  logic [1:0]        size_code_r;
  logic [2:0]        count_code_r;

  // captured command
  logic [1:0]        op_r;
  logic [QNUM_W-1:0] q_r;
  logic [ADDR_W-1:0] addr_r;
  logic [HINT_W-1:0] hint_r;

  // per-command working registers
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              rej_r, rej_nxt;
  logic              empty_r, empty_nxt;
  logic [ADDR_W-1:0] pop_addr_r, pop_addr_nxt;
  logic [HINT_W-1:0] pop_hint_r, pop_hint_nxt;

  // output register
  logic              out_valid_r;
  logic [ADDR_W-1:0] o_addr_r;
  logic [HINT_W-1:0] o_hint_r;
  logic              o_empty_r;
  logic [WORD_W-1:0] o_word_r;
  logic              o_rej_r;

  logic in_acc, out_free, finish;

  // submodule wiring
  alu_req_t          alu_req;
  logic [ADDR_W-1:0] alu_sum;
  logic              alu_borrow;

  logic [IDX_W-1:0]      qt_head, qt_tail, qt_wr_head;
  logic [CNT_W-1:0]      qt_cnt;
  qt_we_t                qt_we;
  logic [NUM_QUEUES-1:0] ne_vec;
  logic [QW-1:0]         qa_r;

  logic              lk_we, lk_hint_we, lk_rd_en;
  logic [IDX_W-1:0]  lk_link;
  logic [HINT_W-1:0] lk_hint;

  // derived values
  logic              q_ok, ne_q;
  logic [CNT_W-1:0]  eff_cnt;
  logic [3:0]        shift;
  logic [ADDR_W-1:0] region_cnt, rc_pow, align_mask, off;
  logic [WORD_W-1:0] ne_words [NW];
  logic [WORD_W-1:0] pend_word;

  assign in_acc   = in_bus.valid & in_bus.ready;
  assign out_free = ~out_valid_r | out_bus.ready;
  assign finish   = (state_r == S_DONE) & out_free;
  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign qa_r    = QW'(q_r);
  assign q_ok    = (32'(q_r) < 32'(NUM_QUEUES));
  assign ne_q    = q_ok & ne_vec[qa_r];
  assign eff_cnt = ne_q ? qt_cnt : '0;
  assign shift   = 4'(size_code_r) + 4'(MIN_LOG);

  // region size in descriptors, capped by the store depth
  always_comb begin
    rc_pow     = 32'd1 << (6'(count_code_r) + 6'(MIN_LOG));
    region_cnt = (rc_pow > 32'(MAX_DESC)) ? 32'(MAX_DESC) : rc_pow;
    align_mask = (32'd1 << shift) - 32'd1;
    off        = alu_sum >> shift;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      size_code_r   <= 2'd0;
      count_code_r  <= 3'd1;
    end else if (cfg_bus.valid & cfg_bus.ready) begin
      case (cfg_bus.index)
        CFG_REGION_BASE: region_base_r <= cfg_bus.data;
        CFG_SIZE_CODE:   size_code_r   <= cfg_bus.data[1:0];
        CFG_COUNT_CODE:  count_code_r  <= cfg_bus.data[2:0];
        default: ;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_bus.opcode;
      q_r    <= in_bus.queue_number;
      addr_r <= in_bus.desc_address & ~LOW_MASK;
      hint_r <= in_bus.size_hint;
    end
  end

  // sequencer and shared adder scheduling
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rej_nxt      = rej_r;
    empty_nxt    = empty_r;
    pop_addr_nxt = pop_addr_r;
    pop_hint_nxt = pop_hint_r;
    alu_req      = '{a: '0, b: '0, sub: 1'b0};
    qt_we        = '0;
    qt_wr_head   = idx_r;
    lk_we        = 1'b0;
    lk_hint_we   = 1'b0;
    lk_rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rej_nxt   = 1'b0;
          empty_nxt = 1'b0;
          case (in_bus.opcode)
            OP_PUSH: state_nxt = S_PCHK;
            OP_POP:  state_nxt = S_POP1;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // offset into region, alignment and range checks
      S_PCHK: begin
        alu_req = '{a: addr_r, b: region_base_r, sub: 1'b1};
        idx_nxt = IDX_W'(off);
        rej_nxt = ~q_ok | (ne_q & (qt_cnt == COUNT_MAX)) | alu_borrow |
                  (|(alu_sum & align_mask)) | (off >= region_cnt);
        state_nxt = rej_nxt ? S_DONE : S_PWR;
      end
      // append to tail, count up
      S_PWR: begin
        alu_req      = '{a: 32'(eff_cnt), b: 32'd1, sub: 1'b0};
        lk_hint_we   = 1'b1;
        lk_we        = ne_q;
        qt_we.head   = ~ne_q;
        qt_we.tail   = 1'b1;
        qt_we.cnt    = 1'b1;
        qt_we.ne_set = 1'b1;
        state_nxt    = S_DONE;
      end
      // rebuild head address, fetch its link entry
      S_POP1: begin
        alu_req      = '{a: region_base_r, b: 32'(qt_head) << shift, sub: 1'b0};
        empty_nxt    = ~ne_q;
        pop_addr_nxt = alu_sum & ~LOW_MASK;
        lk_rd_en     = ne_q;
        state_nxt    = ne_q ? S_POP2 : S_DONE;
      end
      // count down, advance head or mark empty
      S_POP2: begin
        alu_req      = '{a: 32'(eff_cnt), b: 32'd1, sub: 1'b1};
        pop_hint_nxt = lk_hint;
        qt_wr_head   = lk_link;
        qt_we.cnt    = 1'b1;
        qt_we.head   = (alu_sum[CNT_W-1:0] != '0);
        qt_we.ne_clr = (alu_sum[CNT_W-1:0] == '0);
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    rej_r      <= rej_nxt;
    empty_r    <= empty_nxt;
    pop_addr_r <= pop_addr_nxt;
    pop_hint_r <= pop_hint_nxt;
  end

  // pending flags grouped into 32-bit words, zero past the last queue
  for (genvar w = 0; w < NW; w++) begin : g_word
    for (genvar b = 0; b < WORD_W; b++) begin : g_bit
      if (w * WORD_W + b < NUM_QUEUES) begin : g_live
        assign ne_words[w][b] = ne_vec[w * WORD_W + b];
      end else begin : g_pad
        assign ne_words[w][b] = 1'b0;
      end
    end
  end

  assign pend_word = (32'(q_r) < 32'(NW)) ? ne_words[WW'(q_r)] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      o_addr_r  <= (op_r == OP_POP && !empty_r) ? pop_addr_r : '0;
      o_hint_r  <= (op_r == OP_POP && !empty_r) ? pop_hint_r : '0;
      o_empty_r <= (op_r == OP_POP) & empty_r;
      o_word_r  <= (op_r == OP_PEND) ? pend_word : '0;
      o_rej_r   <= (op_r == OP_PUSH) & rej_r;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.popped_address   = o_addr_r;
  assign out_bus.popped_size_hint = o_hint_r;
  assign out_bus.queue_was_empty  = o_empty_r;
  assign out_bus.pending_word     = o_word_r;
  assign out_bus.push_rejected    = o_rej_r;

  dqm_alu u_alu (
    .req    (alu_req),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  dqm_qtable #(
    .NUM_QUEUES (NUM_QUEUES),
    .IDX_W      (IDX_W),
    .QW         (QW)
  ) u_qtable (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (QW'(in_bus.queue_number)),
    .rd_head (qt_head),
    .rd_tail (qt_tail),
    .rd_cnt  (qt_cnt),
    .we      (qt_we),
    .wr_addr (qa_r),
    .wr_head (qt_wr_head),
    .wr_tail (idx_r),
    .wr_cnt  (alu_sum[CNT_W-1:0]),
    .ne      (ne_vec)
  );

  dqm_link_mem #(
    .MAX_DESC (MAX_DESC),
    .IDX_W    (IDX_W)
  ) u_link (
    .clk        (clk),
    .link_we    (lk_we),
    .link_waddr (qt_tail),
    .link_wdata (idx_r),
    .hint_we    (lk_hint_we),
    .hint_waddr (idx_r),
    .hint_wdata (hint_r),
    .rd_en      (lk_rd_en),
    .rd_addr    (qt_head),
    .rd_link    (lk_link),
    .rd_hint    (lk_hint)
  );

`ifndef ASSERT_OFF
  // an accepted command always leaves idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer stayed idle after accepting a command");

  // an accepted push leaves its queue non-empty
  a_push_sets_ne: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PWR |=> ne_vec[qa_r])
    else $error("queue empty after push");

  // the link fetch step is reached only for a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP2 |-> ne_q && $past(lk_rd_en))
    else $error("link step entered for an empty queue");
`endif

endmodule
